// ----- hdl/tcw_pkg.sv -----
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared constants for the text console cell writer: field widths, default
// sizes, character codes and configuration register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

   // default sizes
   localparam int DEF_TERMINALS  = 4;
   localparam int DEF_MAX_COLS   = 128;
   localparam int DEF_MAX_ROWS   = 64;
   localparam int DEF_CELL_DEPTH = DEF_TERMINALS * DEF_MAX_ROWS * DEF_MAX_COLS;
   localparam int DEF_CELL_AW    = $clog2(DEF_CELL_DEPTH);

   // port field widths
   localparam int TERM_W   = 3;
   localparam int CHAR_W   = 8;
   localparam int ROW_W    = 6;
   localparam int COL_W    = 7;
   localparam int WIDTH_W  = 8;
   localparam int HEIGHT_W = 7;
   localparam int ATTR_W   = 8;
   localparam int CELL_W   = CHAR_W + ATTR_W;

   // character codes
   localparam logic [CHAR_W-1:0] CODE_CR    = 8'd13;
   localparam logic [CHAR_W-1:0] CODE_LF    = 8'd10;
   localparam logic [CHAR_W-1:0] CODE_NUL   = 8'd0;
   localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h07;

   // request kinds
   localparam logic REQ_PUT  = 1'b0;
   localparam logic REQ_READ = 1'b1;

   // configuration registers (word index)
   localparam logic [1:0] REG_WIDTH_COLS  = 2'd0;
   localparam logic [1:0] REG_HEIGHT_ROWS = 2'd1;
   localparam logic [1:0] REG_TEXT_ATTR   = 2'd2;

   localparam logic [WIDTH_W-1:0]  RESET_WIDTH  = 8'd79;
   localparam logic [HEIGHT_W-1:0] RESET_HEIGHT = 7'd29;

endpackage : tcw_pkg

`default_nettype wire

// ----- hdl/tcw_cell_ram.sv -----
// ----------------------------------------------------------------------------
// tcw_cell_ram
// Cell store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_cell_ram #(
   parameter int DEPTH  = tcw_pkg::DEF_CELL_DEPTH,
   parameter int ADDR_W = tcw_pkg::DEF_CELL_AW
) (
   input  wire logic                      clock,
   input  wire logic                      wr_en,
   input  wire logic [ADDR_W-1:0]         wr_addr,
   input  wire logic [tcw_pkg::CELL_W-1:0] wr_data,
   input  wire logic [ADDR_W-1:0]         rd_addr,
   output logic      [tcw_pkg::CELL_W-1:0] rd_data
);
   import tcw_pkg::*;

   logic [CELL_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule : tcw_cell_ram

`default_nettype wire

// ----- hdl/text_console_cell_writer_unit.sv -----
// ----------------------------------------------------------------------------
// text_console_cell_writer_unit
// Character-cell buffer for several text terminals. Puts store a byte with
// the current attribute at the cursor, handle CR / LF, wrap and scroll via a
// per-terminal ring offset. Reads return one displayed cell.
// ----------------------------------------------------------------------------
//
//  channel   ports                              handshake
//  --------  ---------------------------------  -------------------------------
//  request   req_type/terminal/char_code/...    word taken when start & !busy
//  result    rsp_accepted/cell_char/...         rsp_valid, one cycle, no stall
//  config    psel/penable/pwrite/paddr/pwdata   APB, written in access phase
//
//  Steps: a put goes through accept (cursor memory read), then S_CUR (cursor
//  update); a read goes through accept (cursor read), S_CUR (cell memory read)
//  and S_CELL. Each step waits on the registered read of the cursor or cell memory.
//  A put that scrolls then fills the new bottom ring row, 2**$clog2(MAX_COLS)
//  cells (128 by default), one cell per cycle on the cell write port.
//  Reset: a clearing pass over all TERMINALS * 2**$clog2(MAX_ROWS) *
//  2**$clog2(MAX_COLS) cells (32768 by default) writes every cell to char 0 /
//  attribute 7 and zeroes the cursor memory; busy is high during it.
//  The result side cannot stall: rsp_valid pulses for exactly one cycle.
//
`default_nettype none

module text_console_cell_writer_unit #(
   parameter int TERMINALS = tcw_pkg::DEF_TERMINALS,
   parameter int MAX_COLS  = tcw_pkg::DEF_MAX_COLS,
   parameter int MAX_ROWS  = tcw_pkg::DEF_MAX_ROWS
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   // request
   input  wire logic                        start,
   output logic                             busy,
   input  wire logic                        req_type,
   input  wire logic [tcw_pkg::TERM_W-1:0]  req_terminal,
   input  wire logic [tcw_pkg::CHAR_W-1:0]  req_char_code,
   input  wire logic [tcw_pkg::ROW_W-1:0]   req_read_row,
   input  wire logic [tcw_pkg::COL_W-1:0]   req_read_col,
   // result
   output logic                             rsp_valid,
   output logic                             rsp_accepted,
   output logic      [tcw_pkg::CHAR_W-1:0]  rsp_cell_char,
   output logic      [tcw_pkg::ATTR_W-1:0]  rsp_cell_attr,
   output logic      [tcw_pkg::COL_W-1:0]   rsp_cursor_col,
   output logic      [tcw_pkg::ROW_W-1:0]   rsp_cursor_row,
   output logic                             rsp_scrolled,
   // configuration
   input  wire logic                        psel,
   input  wire logic                        penable,
   input  wire logic                        pwrite,
   input  wire logic [3:0]                  paddr,
   input  wire logic [31:0]                 pwdata,
   output logic      [31:0]                 prdata,
   output logic                             pready
);
   import tcw_pkg::*;

   // geometry
   localparam int TW     = (TERMINALS > 1) ? $clog2(TERMINALS) : 1;
   localparam int CW     = $clog2(MAX_COLS);
   localparam int RW     = $clog2(MAX_ROWS);
   localparam int DEPTH  = TERMINALS * (2 ** (RW + CW));
   localparam int AW     = $clog2(DEPTH);
   localparam int CUR_W  = 2 * RW + CW;   // {top, row, col}

   // sequencer
   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_CUR   = 3'd2;
   localparam logic [2:0] S_CELL  = 3'd3;
   localparam logic [2:0] S_FILL  = 3'd4;

   logic [2:0]          state_ff;
   logic [AW-1:0]       clr_addr_ff;

   // latched request
   logic                type_ff;
   logic [TERM_W-1:0]   term_ff;
   logic [CHAR_W-1:0]   char_ff;
   logic [ROW_W-1:0]    row_ff;
   logic [COL_W-1:0]    col_ff;
   logic                rd_hit_ff;

   // config
   logic [WIDTH_W-1:0]  width_ff;
   logic [HEIGHT_W-1:0] height_ff;
   logic [ATTR_W-1:0]   attr_ff;

   // scroll fill
   logic [TW+RW-1:0]    fill_row_ff;
   logic [CW-1:0]       fill_col_ff;
   logic [ATTR_W-1:0]   fill_attr_ff;

   // cursor memory, one entry per terminal
   logic [CUR_W-1:0]    cur_mem [TERMINALS];
   logic [CUR_W-1:0]    cur_rd_ff;
   logic                cur_we;
   logic [TW-1:0]       cur_waddr;
   logic [CUR_W-1:0]    cur_wdata;

   // cell memory ports
   logic                cell_we;
   logic [AW-1:0]       cell_waddr;
   logic [CELL_W-1:0]   cell_wdata;
   logic [AW-1:0]       cell_raddr;
   logic [CELL_W-1:0]   cell_rdata;

   // result registers
   logic                rsp_valid_ff;
   logic                rsp_accepted_ff;
   logic [CHAR_W-1:0]   rsp_char_ff;
   logic [ATTR_W-1:0]   rsp_attr_ff;
   logic [COL_W-1:0]    rsp_col_ff;
   logic [ROW_W-1:0]    rsp_row_ff;
   logic                rsp_scrolled_ff;

   // (base + ofs) mod MAX_ROWS; both below MAX_ROWS + 1 so one subtract does
   function automatic logic [RW-1:0] ring_of(input logic [RW-1:0] base,
                                             input logic [6:0] ofs);
      logic [7:0] s;
      s = 8'(base) + 8'(ofs);
      if (s >= 8'(MAX_ROWS)) s = s - 8'(MAX_ROWS);
      return s[RW-1:0];
   endfunction

   // ------------------------------------------------------------------------
   // Step datapath, valid in S_CUR once the cursor entry has been read
   // ------------------------------------------------------------------------
   logic [WIDTH_W-1:0]  w_eff, w_m1;
   logic [HEIGHT_W-1:0] h_eff, h_m1;
   logic [CW-1:0]       cur_col;
   logic [RW-1:0]       cur_row, cur_top;
   logic [CW-1:0]       x_cl;
   logic [RW-1:0]       y_cl;
   logic [WIDTH_W-1:0]  x_inc;
   logic [HEIGHT_W-1:0] y_inc;
   logic [CW-1:0]       nx;
   logic [HEIGHT_W-1:0] ny;
   logic                term_ok;
   logic                put_active;
   logic                put_store;
   logic                do_scroll;
   logic                in_range;
   logic [RW-1:0]       new_top;
   logic [CW-1:0]       fin_col;
   logic [RW-1:0]       fin_row;
   logic [TW-1:0]       t_idx;

   always_comb begin
      // clamp the register sizes
      if (width_ff == '0)                   w_eff = WIDTH_W'(1);
      else if (width_ff > WIDTH_W'(MAX_COLS)) w_eff = WIDTH_W'(MAX_COLS);
      else                                  w_eff = width_ff;
      if (height_ff == '0)                    h_eff = HEIGHT_W'(1);
      else if (height_ff > HEIGHT_W'(MAX_ROWS)) h_eff = HEIGHT_W'(MAX_ROWS);
      else                                    h_eff = height_ff;
      w_m1 = w_eff - WIDTH_W'(1);
      h_m1 = h_eff - HEIGHT_W'(1);

      t_idx   = term_ff[TW-1:0];
      cur_col = cur_rd_ff[CW-1:0];
      cur_row = cur_rd_ff[CW+RW-1:CW];
      cur_top = cur_rd_ff[CUR_W-1:CW+RW];

      // cursor pulled back inside the area after a shrink
      x_cl = (WIDTH_W'(cur_col) > w_m1) ? w_m1[CW-1:0] : cur_col;
      y_cl = (HEIGHT_W'(cur_row) > h_m1) ? h_m1[RW-1:0] : cur_row;
      x_inc = WIDTH_W'(x_cl) + WIDTH_W'(1);
      y_inc = HEIGHT_W'(y_cl) + HEIGHT_W'(1);

      term_ok    = {1'b0, term_ff} < (TERM_W+1)'(TERMINALS);
      put_active = term_ok && (type_ff == REQ_PUT) && (char_ff != CODE_NUL);
      put_store  = 1'b0;

      case (char_ff)
         CODE_CR: begin
            nx = '0;
            ny = HEIGHT_W'(y_cl);
         end
         CODE_LF: begin
            nx = '0;
            ny = y_inc;
         end
         default: begin
            put_store = put_active;
            if (x_inc >= w_eff) begin
               nx = '0;
               ny = y_inc;
            end else begin
               nx = x_inc[CW-1:0];
               ny = HEIGHT_W'(y_cl);
            end
         end
      endcase

      do_scroll = ny >= h_eff;
      new_top   = do_scroll ? ring_of(cur_top, 7'd1) : cur_top;
      fin_col   = do_scroll ? '0 : nx;
      fin_row   = do_scroll ? h_m1[RW-1:0] : ny[RW-1:0];

      in_range = ({1'b0, row_ff} < h_eff) && ({1'b0, col_ff} < w_eff);
   end

   // ------------------------------------------------------------------------
   // Memory port steering
   // ------------------------------------------------------------------------
   always_comb begin
      cell_we    = 1'b0;
      cell_waddr = clr_addr_ff;
      cell_wdata = {RESET_ATTR, CODE_NUL};
      case (state_ff)
         S_CLEAR: begin
            cell_we = 1'b1;
         end
         S_FILL: begin
            cell_we    = 1'b1;
            cell_waddr = AW'({fill_row_ff, fill_col_ff});
            cell_wdata = {fill_attr_ff, CODE_NUL};
         end
         S_CUR: begin
            cell_we    = put_store;
            cell_waddr = AW'({t_idx, ring_of(cur_top, 7'(y_cl)), x_cl});
            cell_wdata = {attr_ff, char_ff};
         end
         default: begin
            cell_we = 1'b0;
         end
      endcase
      // displayed row -> ring row; only used when the read is in range
      cell_raddr = AW'({t_idx, ring_of(cur_top, 7'(row_ff)), col_ff[CW-1:0]});

      cur_we    = 1'b0;
      cur_waddr = clr_addr_ff[TW-1:0];
      cur_wdata = '0;
      if (state_ff == S_CLEAR) begin
         cur_we = clr_addr_ff < AW'(TERMINALS);
      end else if (state_ff == S_CUR) begin
         cur_we    = put_active;
         cur_waddr = t_idx;
         cur_wdata = {new_top, fin_row, fin_col};
      end
   end

   tcw_cell_ram #(
      .DEPTH  (DEPTH),
      .ADDR_W (AW)
   ) u_cell_ram (
      .clock   (clock),
      .wr_en   (cell_we),
      .wr_addr (cell_waddr),
      .wr_data (cell_wdata),
      .rd_addr (cell_raddr),
      .rd_data (cell_rdata)
   );

   // cursor memory: cleared in S_CLEAR, written in S_CUR, read at accept; accesses never overlap
   always_ff @(posedge clock) begin
      if (cur_we) begin
         cur_mem[cur_waddr] <= cur_wdata;
      end
      if (state_ff == S_IDLE) begin
         cur_rd_ff <= cur_mem[req_terminal[TW-1:0]];
      end
   end

   // ------------------------------------------------------------------------
   // Sequencer and result registers
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_CLEAR: begin
               clr_addr_ff <= clr_addr_ff + AW'(1);
               if (clr_addr_ff == AW'(DEPTH - 1)) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (start) begin
                  type_ff  <= req_type;
                  term_ff  <= req_terminal;
                  char_ff  <= req_char_code;
                  row_ff   <= req_read_row;
                  col_ff   <= req_read_col;
                  state_ff <= S_CUR;
               end
            end
            S_CUR: begin
               // defaults: report the stored cursor, no cell
               rsp_accepted_ff <= term_ok;
               rsp_char_ff     <= '0;
               rsp_attr_ff     <= '0;
               rsp_scrolled_ff <= 1'b0;
               rsp_col_ff      <= term_ok ? COL_W'(cur_col) : '0;
               rsp_row_ff      <= term_ok ? ROW_W'(cur_row) : '0;
               state_ff        <= S_IDLE;
               if (term_ok && type_ff == REQ_READ) begin
                  rd_hit_ff <= in_range;
                  state_ff  <= S_CELL;   // result once the cell read lands
               end else begin
                  rsp_valid_ff <= 1'b1;
                  if (put_active) begin
                     rsp_col_ff      <= COL_W'(fin_col);
                     rsp_row_ff      <= ROW_W'(fin_row);
                     rsp_scrolled_ff <= do_scroll;
                     if (do_scroll) begin
                        // new bottom ring row = old top + height
                        fill_row_ff  <= {t_idx, ring_of(cur_top, h_eff)};
                        fill_col_ff  <= '0;
                        fill_attr_ff <= attr_ff;
                        state_ff     <= S_FILL;
                     end
                  end
               end
            end
            S_CELL: begin
               rsp_valid_ff <= 1'b1;
               rsp_char_ff  <= rd_hit_ff ? cell_rdata[CHAR_W-1:0] : '0;
               rsp_attr_ff  <= rd_hit_ff ? cell_rdata[CELL_W-1:CHAR_W] : '0;
               state_ff     <= S_IDLE;
            end
            S_FILL: begin
               fill_col_ff <= fill_col_ff + CW'(1);
               if (fill_col_ff == '1) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= RESET_WIDTH;
         height_ff <= RESET_HEIGHT;
         attr_ff   <= RESET_ATTR;
      end else if (psel && penable && pwrite) begin
         case (paddr[3:2])
            REG_WIDTH_COLS:  width_ff  <= pwdata[WIDTH_W-1:0];
            REG_HEIGHT_ROWS: height_ff <= pwdata[HEIGHT_W-1:0];
            REG_TEXT_ATTR:   attr_ff   <= pwdata[ATTR_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         REG_WIDTH_COLS:  prdata = 32'(width_ff);
         REG_HEIGHT_ROWS: prdata = 32'(height_ff);
         REG_TEXT_ATTR:   prdata = 32'(attr_ff);
         default:         prdata = '0;
      endcase
   end

   assign pready         = 1'b1;
   assign busy           = state_ff != S_IDLE;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_accepted   = rsp_accepted_ff;
   assign rsp_cell_char  = rsp_char_ff;
   assign rsp_cell_attr  = rsp_attr_ff;
   assign rsp_cursor_col = rsp_col_ff;
   assign rsp_cursor_row = rsp_row_ff;
   assign rsp_scrolled   = rsp_scrolled_ff;

endmodule : text_console_cell_writer_unit

`default_nettype wire

// ----- hdl/tcw_checker.sv -----
// ----------------------------------------------------------------------------
// tcw_checker
// Port-level checks on the cell writer: busy after reset and accept, result
// strobe spacing, and the shape of rejected and scrolled results.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        start,
   input wire logic                        busy,
   input wire logic                        rsp_valid,
   input wire logic                        rsp_accepted,
   input wire logic [tcw_pkg::CHAR_W-1:0]  rsp_cell_char,
   input wire logic [tcw_pkg::ATTR_W-1:0]  rsp_cell_attr,
   input wire logic [tcw_pkg::COL_W-1:0]   rsp_cursor_col,
   input wire logic [tcw_pkg::ROW_W-1:0]   rsp_cursor_row,
   input wire logic                        rsp_scrolled
);
   import tcw_pkg::*;

   // clearing pass holds the block off after reset
   a_reset_busy: assert property (@(posedge clock) reset |=> busy)
      else $error("busy low right after reset");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy low after an accepted word");

   a_strobe_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("back-to-back result strobes");

   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_accepted) |->
         (rsp_cell_char == CHAR_W'(0) && rsp_cell_attr == ATTR_W'(0) &&
          rsp_cursor_col == COL_W'(0) && rsp_cursor_row == ROW_W'(0) &&
          !rsp_scrolled))
      else $error("rejected word with nonzero result fields");

   a_scroll_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_scrolled) |->
         (rsp_accepted && rsp_cursor_col == COL_W'(0) &&
          rsp_cell_char == CHAR_W'(0) && rsp_cell_attr == ATTR_W'(0)))
      else $error("scrolled result with bad fields");

endmodule : tcw_checker

bind text_console_cell_writer_unit tcw_checker u_tcw_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .rsp_valid      (rsp_valid),
   .rsp_accepted   (rsp_accepted),
   .rsp_cell_char  (rsp_cell_char),
   .rsp_cell_attr  (rsp_cell_attr),
   .rsp_cursor_col (rsp_cursor_col),
   .rsp_cursor_row (rsp_cursor_row),
   .rsp_scrolled   (rsp_scrolled)
);

`default_nettype wire

// ----- tb/console_cell_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// console_cell_checker
// Watches the request, result and register ports of the cell writer, keeps
// its own copy of every terminal's cells, cursor and scroll offset, and checks
// each result word against the predicted one in arrival order.
// ----------------------------------------------------------------------------

module console_cell_checker (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic                        busy,
   input  wire logic                        req_type,
   input  wire logic [tcw_pkg::TERM_W-1:0]  req_terminal,
   input  wire logic [tcw_pkg::CHAR_W-1:0]  req_char_code,
   input  wire logic [tcw_pkg::ROW_W-1:0]   req_read_row,
   input  wire logic [tcw_pkg::COL_W-1:0]   req_read_col,
   input  wire logic                        rsp_valid,
   input  wire logic                        rsp_accepted,
   input  wire logic [tcw_pkg::CHAR_W-1:0]  rsp_cell_char,
   input  wire logic [tcw_pkg::ATTR_W-1:0]  rsp_cell_attr,
   input  wire logic [tcw_pkg::COL_W-1:0]   rsp_cursor_col,
   input  wire logic [tcw_pkg::ROW_W-1:0]   rsp_cursor_row,
   input  wire logic                        rsp_scrolled,
   input  wire logic                        psel,
   input  wire logic                        penable,
   input  wire logic                        pwrite,
   input  wire logic [3:0]                  paddr,
   input  wire logic [31:0]                 pwdata,
   input  wire logic                        pready,
   output int                               error_count,
   output int                               words_due
);
   import tcw_pkg::*;

   localparam int TERMS      = DEF_TERMINALS;
   localparam int NCOLS      = DEF_MAX_COLS;
   localparam int NROWS      = DEF_MAX_ROWS;
   localparam int TERM_CELLS = NCOLS * NROWS;

   typedef struct packed {
      logic              accepted;
      logic [CHAR_W-1:0] cell_char;
      logic [ATTR_W-1:0] cell_attr;
      logic [COL_W-1:0]  cursor_col;
      logic [ROW_W-1:0]  cursor_row;
      logic              scrolled;
   } console_reply_type;

   logic [CELL_W-1:0]   screen_cells [0:TERMS*TERM_CELLS-1];
   logic [COL_W-1:0]    col_at       [0:TERMS-1];
   logic [ROW_W-1:0]    row_at       [0:TERMS-1];
   logic [ROW_W-1:0]    ring_top     [0:TERMS-1];
   logic [WIDTH_W-1:0]  width_reg;
   logic [HEIGHT_W-1:0] height_reg;
   logic [ATTR_W-1:0]   attr_reg;
   console_reply_type   replies_due [$];
   int                  mismatches = 0;

   // displayed row r of terminal t lives in ring row (top + r) mod NROWS
   function automatic int cell_addr(int t, int r, int c);
      return t * TERM_CELLS + ((ring_top[t] + r) % NROWS) * NCOLS + c;
   endfunction

   function automatic console_reply_type advance_console(
      logic kind, logic [TERM_W-1:0] term, logic [CHAR_W-1:0] code,
      logic [ROW_W-1:0] rrow, logic [COL_W-1:0] rcol);
      console_reply_type rep;
      int w, h, x, y, t, base, c;
      rep = '0;
      w = (width_reg == 0) ? 1 : ((width_reg > NCOLS) ? NCOLS : int'(width_reg));
      h = (height_reg == 0) ? 1 : ((height_reg > NROWS) ? NROWS : int'(height_reg));
      if (term >= TERMS)
         return rep;
      t = term;
      if (kind == REQ_READ) begin
         if (rrow < h && rcol < w)
            {rep.cell_attr, rep.cell_char} = screen_cells[cell_addr(t, rrow, rcol)];
      end else if (code != CODE_NUL) begin
         x = col_at[t];
         y = row_at[t];
         // sizes may have shrunk under the cursor
         if (x > w - 1) x = w - 1;
         if (y > h - 1) y = h - 1;
         if (code == CODE_CR) begin
            x = 0;
         end else if (code == CODE_LF) begin
            x = 0;
            y++;
         end else begin
            screen_cells[cell_addr(t, y, x)] = {attr_reg, code};
            x++;
            if (x >= w) begin
               x = 0;
               y++;
            end
         end
         if (y >= h) begin
            // scroll: bump ring offset, blank the whole new bottom ring row
            ring_top[t] = ring_top[t] + 1'b1;
            base = cell_addr(t, h - 1, 0);
            for (c = 0; c < NCOLS; c++)
               screen_cells[base + c] = {attr_reg, CODE_NUL};
            col_at[t]    = '0;
            row_at[t]    = ROW_W'(h - 1);
            rep.scrolled = 1'b1;
         end else begin
            col_at[t] = COL_W'(x);
            row_at[t] = ROW_W'(y);
         end
      end
      rep.accepted   = 1'b1;
      rep.cursor_col = col_at[t];
      rep.cursor_row = row_at[t];
      return rep;
   endfunction

   function automatic void flag(string field, int want, int got);
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatches++;
   endfunction

   function automatic void check_reply(console_reply_type want, console_reply_type got);
      if (got.accepted   !== want.accepted)   flag("accepted", want.accepted, got.accepted);
      if (got.cell_char  !== want.cell_char)  flag("cell_char", want.cell_char, got.cell_char);
      if (got.cell_attr  !== want.cell_attr)  flag("cell_attr", want.cell_attr, got.cell_attr);
      if (got.cursor_col !== want.cursor_col)
         flag("cursor_col", want.cursor_col, got.cursor_col);
      if (got.cursor_row !== want.cursor_row)
         flag("cursor_row", want.cursor_row, got.cursor_row);
      if (got.scrolled   !== want.scrolled)   flag("scrolled", want.scrolled, got.scrolled);
   endfunction

   always @(posedge clock) begin
      console_reply_type got;
      if (reset) begin
         for (int i = 0; i < TERMS * TERM_CELLS; i++)
            screen_cells[i] = {RESET_ATTR, CODE_NUL};
         for (int i = 0; i < TERMS; i++) begin
            col_at[i]   = '0;
            row_at[i]   = '0;
            ring_top[i] = '0;
         end
         width_reg  = RESET_WIDTH;
         height_reg = RESET_HEIGHT;
         attr_reg   = RESET_ATTR;
         replies_due.delete();
      end else begin
         // results first: a word accepted this edge cannot answer yet
         if (rsp_valid) begin
            got = {rsp_accepted, rsp_cell_char, rsp_cell_attr,
                   rsp_cursor_col, rsp_cursor_row, rsp_scrolled};
            if (replies_due.size() == 0) begin
               $error("result word with no request outstanding");
               mismatches++;
            end else begin
               check_reply(replies_due.pop_front(), got);
            end
         end
         if (psel && penable && pwrite && pready) begin
            case (paddr[3:2])
               REG_WIDTH_COLS:  width_reg  = pwdata[WIDTH_W-1:0];
               REG_HEIGHT_ROWS: height_reg = pwdata[HEIGHT_W-1:0];
               REG_TEXT_ATTR:   attr_reg   = pwdata[ATTR_W-1:0];
               default: ;
            endcase
         end
         if (start && !busy)
            replies_due.push_back(advance_console(req_type, req_terminal, req_char_code,
                                                  req_read_row, req_read_col));
      end
      words_due   <= replies_due.size();
      error_count <= mismatches;
   end

endmodule

// ----- tb/text_console_cell_writer_unit_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// text_console_cell_writer_unit_test
// Drives put and read words into the console cell writer through a series of
// screen-size and attribute settings, with a bursty sender. A checker beside
// the block predicts every result word; this module gives the verdict.
// ----------------------------------------------------------------------------

module text_console_cell_writer_unit_test;
   import tcw_pkg::*;

   localparam int TERMS           = DEF_TERMINALS;
   localparam int FIXED_PHASES    = 7;
   localparam int PHASES          = 12;
   localparam int WORDS_PER_PHASE = 100;
   // a scroll holds the block for one full ring row plus the put itself
   localparam int DRAIN_CYCLES    = 2 * DEF_MAX_COLS;
   // clearing pass plus ~1350 words, each at its worst, then x4
   localparam int CYCLE_LIMIT     = 1_000_000;

   logic                clock = 1'b0;
   logic                reset;
   logic                start;
   logic                busy;
   logic                req_type;
   logic [TERM_W-1:0]   req_terminal;
   logic [CHAR_W-1:0]   req_char_code;
   logic [ROW_W-1:0]    req_read_row;
   logic [COL_W-1:0]    req_read_col;
   logic                rsp_valid;
   logic                rsp_accepted;
   logic [CHAR_W-1:0]   rsp_cell_char;
   logic [ATTR_W-1:0]   rsp_cell_attr;
   logic [COL_W-1:0]    rsp_cursor_col;
   logic [ROW_W-1:0]    rsp_cursor_row;
   logic                rsp_scrolled;
   logic                psel;
   logic                penable;
   logic                pwrite;
   logic [3:0]          paddr;
   logic [31:0]         pwdata;
   logic [31:0]         prdata;
   logic                pready;

   int error_count;
   int words_due;
   int cycle_count = 0;

   // sizes in force, clamped the way the block clamps them; used to aim reads
   int eff_w = int'(RESET_WIDTH);
   int eff_h = int'(RESET_HEIGHT);
   int burst_left = 0;

   // fixed settings: out-of-range low, out-of-range high, a shrink that leaves
   // the cursor outside the area, single row, single column, tiny, typical
   int fixed_w    [FIXED_PHASES] = '{0,   255, 3,  128, 1,  8,   80};
   int fixed_h    [FIXED_PHASES] = '{0,   127, 2,  1,   64, 4,   25};
   int fixed_attr [FIXED_PHASES] = '{255, 0,   90, 165, 60, 195, 31};

   text_console_cell_writer_unit u_top (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_type       (req_type),
      .req_terminal   (req_terminal),
      .req_char_code  (req_char_code),
      .req_read_row   (req_read_row),
      .req_read_col   (req_read_col),
      .rsp_valid      (rsp_valid),
      .rsp_accepted   (rsp_accepted),
      .rsp_cell_char  (rsp_cell_char),
      .rsp_cell_attr  (rsp_cell_attr),
      .rsp_cursor_col (rsp_cursor_col),
      .rsp_cursor_row (rsp_cursor_row),
      .rsp_scrolled   (rsp_scrolled),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready)
   );

   console_cell_checker u_cells_check (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_type       (req_type),
      .req_terminal   (req_terminal),
      .req_char_code  (req_char_code),
      .req_read_row   (req_read_row),
      .req_read_col   (req_read_col),
      .rsp_valid      (rsp_valid),
      .rsp_accepted   (rsp_accepted),
      .rsp_cell_char  (rsp_cell_char),
      .rsp_cell_attr  (rsp_cell_attr),
      .rsp_cursor_col (rsp_cursor_col),
      .rsp_cursor_row (rsp_cursor_row),
      .rsp_scrolled   (rsp_scrolled),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .pready         (pready),
      .error_count    (error_count),
      .words_due      (words_due)
   );

   always #4 clock = ~clock;

   // watchdog: a hung handshake ends the run as a failure
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("text_console_cell_writer_unit_test: done, errors");
         $finish;
      end
   end

   // Present one request word and hold it until the block takes it. Returns
   // in the time step of the accepting edge with start still high, so a
   // following word can go out back to back with a single assignment.
   task automatic issue(logic kind, logic [TERM_W-1:0] term, logic [CHAR_W-1:0] code,
                        logic [ROW_W-1:0] row, logic [COL_W-1:0] col);
      req_type      <= kind;
      req_terminal  <= term;
      req_char_code <= code;
      req_read_row  <= row;
      req_read_col  <= col;
      start         <= 1'b1;
      do @(posedge clock); while (busy);
   endtask

   // fields the operation ignores still get random bits so every bit toggles
   task automatic put_char(int term, logic [CHAR_W-1:0] code);
      issue(REQ_PUT, TERM_W'(term), code, ROW_W'($urandom), COL_W'($urandom));
   endtask

   task automatic read_cell(int term, int row, int col);
      issue(REQ_READ, TERM_W'(term), CHAR_W'($urandom), ROW_W'(row), COL_W'(col));
   endtask

   // Drop start and wait until every word has answered and the block is idle.
   // Every word yields a result, so an empty checker queue plus !busy means
   // nothing is left in flight. The first edge lets the checker count update.
   task automatic settle();
      start <= 1'b0;
      @(posedge clock);
      while (words_due != 0 || busy) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // APB write: setup cycle, then access cycle; the write lands on the edge
   // that closes the access cycle. The bus then returns to idle.
   task automatic write_reg(logic [1:0] idx, logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_screen(int w, int h, int attr);
      settle();
      write_reg(REG_WIDTH_COLS, w);
      write_reg(REG_HEIGHT_ROWS, h);
      write_reg(REG_TEXT_ATTR, attr);
      eff_w = (w == 0) ? 1 : ((w > DEF_MAX_COLS) ? DEF_MAX_COLS : w);
      eff_h = (h == 0) ? 1 : ((h > DEF_MAX_ROWS) ? DEF_MAX_ROWS : h);
   endtask

   // Sender pacing: bursts of random length, mostly short, now and then a
   // long stretch with no gaps at all; gaps land on any phase of the block.
   task automatic pace();
      if (burst_left == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                  : $urandom_range(1, 10);
      end
      burst_left--;
   endtask

   // One random word. Puts are weighted toward CR / LF so cursors travel and
   // terminals scroll often; reads are mostly aimed inside the area in use.
   task automatic random_word(output bit counted);
      logic [TERM_W-1:0] term;
      logic [CHAR_W-1:0] code;
      int                pick;
      term = ($urandom_range(0, 9) == 0) ? TERM_W'($urandom_range(TERMS, 7))
                                         : TERM_W'($urandom_range(0, TERMS - 1));
      if ($urandom_range(0, 9) < 3) begin
         if ($urandom_range(0, 3) != 0)
            read_cell(int'(term), $urandom_range(0, eff_h - 1),
                      $urandom_range(0, eff_w - 1));
         else
            read_cell(int'(term), $urandom_range(0, 63), $urandom_range(0, 127));
      end else begin
         pick = $urandom_range(0, 19);
         if (pick < 4)       code = CODE_LF;
         else if (pick < 7)  code = CODE_CR;
         else if (pick == 7) code = CODE_NUL;
         else                code = CHAR_W'($urandom_range(1, 255));
         put_char(int'(term), code);
      end
      // rejected terminals are just noise and do not count toward the phase
      counted = (term < TERMS);
   endtask

   initial begin
      int w, h, attr, n;
      bit counted;

      reset         <= 1'b1;
      start         <= 1'b0;
      req_type      <= REQ_PUT;
      req_terminal  <= '0;
      req_char_code <= CODE_NUL;
      req_read_row  <= '0;
      req_read_col  <= '0;
      psel          <= 1'b0;
      penable       <= 1'b0;
      pwrite        <= 1'b0;
      paddr         <= '0;
      pwdata        <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // busy covers the clearing pass after reset
      settle();

      // --- directed, reset sizes (79 x 29, attribute 7) ---
      read_cell(0, 0, 0);                     // fresh cell: char 0, attr 7
      read_cell(0, 63, 127);                  // both coordinates out of area
      read_cell(0, RESET_HEIGHT - 1, RESET_WIDTH - 1);   // last cell in area
      put_char(0, 8'h41);
      put_char(0, 8'hFF);
      put_char(0, 8'h01);
      read_cell(0, 0, 0);
      read_cell(0, 0, 2);
      put_char(0, CODE_CR);
      put_char(0, CODE_LF);
      put_char(0, CODE_NUL);                  // no-op, cursor still reported
      put_char(4, 8'h42);                     // rejected terminal, put
      issue(REQ_READ, TERM_W'(7), 8'hFF, 6'h3F, 7'h7F);   // rejected terminal, read
      put_char(3, 8'h7A);
      read_cell(3, 0, 0);
      put_char(1, 8'h80);

      for (int p = 0; p < PHASES; p++) begin
         if (p < FIXED_PHASES) begin
            w    = fixed_w[p];
            h    = fixed_h[p];
            attr = fixed_attr[p];
         end else begin
            case ($urandom_range(0, 3))
               0, 1:    w = $urandom_range(1, 16);
               2:       w = $urandom_range(17, 128);
               default: w = $urandom_range(0, 255);
            endcase
            h    = $urandom_range(0, 1) ? $urandom_range(1, 8) : $urandom_range(0, 127);
            attr = $urandom_range(0, 255);
         end
         set_screen(w, h, attr);

         if (p == 0) begin
            // zero sizes act as 1 x 1: every printable put and LF scrolls
            put_char(0, 8'h78);
            put_char(0, CODE_LF);
            put_char(0, CODE_CR);
            read_cell(0, 0, 0);               // blank fill with new attribute
            read_cell(0, 0, 1);               // column beyond the area
         end

         n = 0;
         while (n < WORDS_PER_PHASE) begin
            pace();
            random_word(counted);
            if (counted) n++;
         end
      end

      // drain, then allow a full scroll's worth of cycles for stray words
      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0 && words_due == 0)
         $display("text_console_cell_writer_unit_test: done, clean");
      else
         $display("text_console_cell_writer_unit_test: done, errors");
      $finish;
   end

endmodule
